// File: hdl/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg: shared types and constants for the decimal ASCII converter
// Holds the ASCII codes, the BCD adjust constants, the command codes, the
// queue geometry and the control types that travel between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package itda_pkg;

  // Command codes carried on the input tuser bit
  localparam logic CMD_SIGNED   = 1'b0;
  localparam logic CMD_UNSIGNED = 1'b1;

  // Result field widths
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 4;
  localparam int OUT_DATA_W = ((CHAR_W + COUNT_W + 7) / 8) * 8;

  // ASCII codes
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  // Double-dabble adjust: a digit of five or more gets three added before the shift
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  // Queue between the classifier and the converter
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // Converter sequencer
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SHIFT = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } itda_state_t;

  // Classifier to queue: write strobe and the sign decision
  typedef struct packed {
    logic push;
    logic neg;
  } itda_push_t;

  // Queue status seen by the classifier and the converter
  typedef struct packed {
    logic full;
    logic valid;
  } itda_qstat_t;

endpackage

`default_nettype wire

// File: hdl/int_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_core: binary word to decimal ASCII text
// Prints each input word as decimal characters, signed or unsigned, one
// character per output transaction, most significant digit first.
// ----------------------------------------------------------------------------
// Each input transaction carries a VALUE_BITS-bit word (in_tdata) and a
// command on in_tuser: 0 reads the word as signed two's complement, 1 as
// unsigned. The output stream carries the text without leading zeros, a
// leading '-' for negative signed values (the most negative value prints
// exactly), and a single '0' for zero. out_tlast marks the final character,
// which also carries the character count in out_tdata[11:8]; other characters
// carry a zero count. A word is dequeued, shifted into BCD one magnitude
// bit per cycle, then the digit positions are scanned from the top down to
// the leading digit, then the characters are emitted, most significant first.
// A two-entry queue behind the input lets up to two further words be
// accepted while one is converted. No state is kept between words.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_decimal_ascii_core
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]   in_tdata,   // value
  input  wire logic                              in_tuser,   // cmd
  // Output stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [OUT_DATA_W-1:0]                  out_tdata,  // char_out, char_count
  output logic                                   out_tlast   // is_last
);

  itda_qstat_t           qstat;
  itda_push_t            push;
  logic [VALUE_BITS-1:0] front_mag;
  logic                  q_pop;
  logic                  q_neg;
  logic [VALUE_BITS-1:0] q_mag;
  logic [CHAR_W-1:0]     out_char;
  logic [COUNT_W-1:0]    out_count;

  // Classifier
  itda_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .cmd      (in_tuser),
    .value    (in_tdata[VALUE_BITS-1:0]),
    .qstat    (qstat),
    .push     (push),
    .mag      (front_mag)
  );

  // Decoupling queue
  itda_queue #(
    .VALUE_BITS(VALUE_BITS)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wr_mag(front_mag),
    .pop   (q_pop),
    .qstat (qstat),
    .rd_neg(q_neg),
    .rd_mag(q_mag)
  );

  // Converter and emitter
  itda_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .qstat     (qstat),
    .q_neg     (q_neg),
    .q_mag     (q_mag),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast),
    .out_count (out_count)
  );

  // Output packing: character in the low byte, count above it
  assign out_tdata = {{(OUT_DATA_W-CHAR_W-COUNT_W){1'b0}}, out_count, out_char};

endmodule

`default_nettype wire

// File: hdl/itda_front.sv
// ----------------------------------------------------------------------------
// itda_front: input classifier
// Takes an input transaction, decides whether a minus sign is due and forms
// the unsigned magnitude (two's complement negation for negative values).
// ----------------------------------------------------------------------------
`default_nettype none

module itda_front
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic                  cmd,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire itda_qstat_t           qstat,
  output itda_push_t                 push,
  output logic      [VALUE_BITS-1:0] mag
);

  logic neg;

  // Accept whenever the queue has room
  assign in_tready = !qstat.full;

  // Sign detect: only a signed reading with the top bit set is negative
  assign neg = (cmd == CMD_SIGNED) && value[VALUE_BITS-1];

  // Magnitude; the most negative value negates to itself, which is the right
  // unsigned magnitude
  assign mag = neg ? (~value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value;

  assign push.push = in_tvalid && in_tready;
  assign push.neg  = neg;

endmodule

`default_nettype wire

// File: hdl/itda_queue.sv
// ----------------------------------------------------------------------------
// itda_queue: two-entry queue between classifier and converter
// Stores sign flag and magnitude so that input and conversion stall
// independently.
// ----------------------------------------------------------------------------
`default_nettype none

module itda_queue
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire itda_push_t            push,
  input  wire logic [VALUE_BITS-1:0] wr_mag,
  input  wire logic                  pop,
  output itda_qstat_t                qstat,
  output logic                       rd_neg,
  output logic      [VALUE_BITS-1:0] rd_mag
);

  localparam int ENTRY_W = VALUE_BITS + 1;

  logic [ENTRY_W-1:0]   mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_PTR_W:0]   count_r, count_nxt;
  logic                   do_pop;

  assign do_pop = pop && (count_r != '0);

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push.push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.push) begin
      mem_r[wr_ptr_r] <= {push.neg, wr_mag};
    end
  end

  assign qstat.full  = (count_r == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign qstat.valid = (count_r != '0);
  assign rd_neg      = mem_r[rd_ptr_r][VALUE_BITS];
  assign rd_mag      = mem_r[rd_ptr_r][VALUE_BITS-1:0];

  // Fill level never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

endmodule

`default_nettype wire

// File: hdl/itda_back.sv
// ----------------------------------------------------------------------------
// itda_back: binary to BCD converter and character emitter
// Runs a shift-and-add-three pass over the magnitude, one bit a cycle, skips
// leading zero digits, then emits the sign and the digits through an output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module itda_back
  import itda_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire itda_qstat_t           qstat,
  input  wire logic                  q_neg,
  input  wire logic [VALUE_BITS-1:0] q_mag,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [CHAR_W-1:0]          out_char,
  output logic                       out_last,
  output logic [COUNT_W-1:0]         out_count
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int BIT_W = $clog2(VALUE_BITS);
  localparam int SUM_W = IDX_W + 2;

  itda_state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] shreg_r, shreg_nxt;
  logic [3:0]            digit_r [MAX_DIGITS];
  logic [3:0]            digit_nxt [MAX_DIGITS];
  logic [3:0]            adj [MAX_DIGITS];
  logic                  ovf_r, ovf_nxt;
  logic                  neg_r, neg_nxt;
  logic [BIT_W-1:0]      bit_cnt_r, bit_cnt_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [COUNT_W-1:0]    total_r, total_nxt;
  logic [SUM_W-1:0]      total_sum;
  logic [3:0]            cur_digit;
  logic                  slot_free;

  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;

  assign slot_free = !out_valid_r || out_tready;
  assign cur_digit = digit_r[idx_r];
  assign total_sum = SUM_W'(idx_r) + SUM_W'(1) + SUM_W'(neg_r);

  // Add-three adjust on every digit ahead of the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (digit_r[i] >= BCD_ADJ_MIN) ? digit_r[i] + BCD_ADJ : digit_r[i];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    shreg_nxt     = shreg_r;
    digit_nxt     = digit_r;
    ovf_nxt       = ovf_r;
    neg_nxt       = neg_r;
    bit_cnt_nxt   = bit_cnt_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_count_nxt = out_count_r;

    case (state_r)
      ST_IDLE: begin
        if (qstat.valid) begin
          q_pop       = 1'b1;
          shreg_nxt   = q_mag;
          neg_nxt     = q_neg;
          ovf_nxt     = 1'b0;
          bit_cnt_nxt = BIT_W'(VALUE_BITS - 1);
          for (int i = 0; i < MAX_DIGITS; i++) begin
            digit_nxt[i] = '0;
          end
          state_nxt   = ST_SHIFT;
        end
      end

      // One magnitude bit into the BCD digits per cycle
      ST_SHIFT: begin
        digit_nxt[0] = {adj[0][2:0], shreg_r[VALUE_BITS-1]};
        for (int i = 1; i < MAX_DIGITS; i++) begin
          digit_nxt[i] = {adj[i][2:0], adj[i-1][3]};
        end
        // A carry out of the top digit means the number has more digits than kept
        ovf_nxt   = ovf_r || adj[MAX_DIGITS-1][3];
        shreg_nxt = {shreg_r[VALUE_BITS-2:0], 1'b0};
        if (bit_cnt_r == '0) begin
          idx_nxt   = IDX_W'(MAX_DIGITS - 1);
          state_nxt = ST_SCAN;
        end else begin
          bit_cnt_nxt = bit_cnt_r - 1'b1;
        end
      end

      // Walk down past leading zeros; the ones digit always prints
      ST_SCAN: begin
        if (!ovf_r && (cur_digit == '0) && (idx_r != '0)) begin
          idx_nxt = idx_r - 1'b1;
        end else begin
          total_nxt = COUNT_W'(total_sum);
          state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
        end
      end

      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
          out_count_nxt = '0;
          state_nxt     = ST_DIGIT;
        end
      end

      // Digits, most significant first
      ST_DIGIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, cur_digit};
          out_last_nxt  = (idx_r == '0);
          out_count_nxt = (idx_r == '0) ? total_r : '0;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    shreg_r     <= shreg_nxt;
    digit_r     <= digit_nxt;
    ovf_r       <= ovf_nxt;
    neg_r       <= neg_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    idx_r       <= idx_nxt;
    total_r     <= total_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_char   = out_char_r;
  assign out_last   = out_last_r;
  assign out_count  = out_count_r;

  // The sign stage is reached only for negative numbers
  a_sign_only_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIGN) |-> neg_r)
    else $error("sign stage without negative flag");

  // The shift pass does not end before its bit count runs out
  a_shift_len: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SHIFT) && (bit_cnt_r != '0)) |=> (state_r == ST_SHIFT))
    else $error("shift pass ended early");

  // Only the final character of a number carries a count
  a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_count_r == '0))
    else $error("count on a non-final character");

  // Last digit emitted returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIGIT) && slot_free && (idx_r == '0)) |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle");

endmodule

`default_nettype wire
